// File: sv/tbpe_pkg.sv
// ----------------------------------------------------------------------------
// tbpe_pkg
// Shared types, command codes and register defaults of the tape pulse encoder.
// ----------------------------------------------------------------------------
package tbpe_pkg;

  localparam int unsigned LEN_W   = 16;
  localparam int unsigned REP_W   = 13;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_A_W = 3;

  localparam int unsigned HEADER_PILOT_PULSES_DEF = 4032;
  localparam int unsigned DATA_PILOT_PULSES_DEF   = 1610;
  localparam int unsigned JOB_QUEUE_DEPTH_DEF     = 4;

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_PILOT_LOW  = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_PILOT_HIGH = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_SYNC_LOW   = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_SYNC_HIGH  = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_LONG_LOW   = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_LONG_HIGH  = 3'd5;
  localparam logic [CFG_A_W-1:0] REG_SHORT_LOW  = 3'd6;
  localparam logic [CFG_A_W-1:0] REG_SHORT_HIGH = 3'd7;

  // Register reset values
  localparam logic [LEN_W-1:0] PILOT_LOW_RST  = 16'd27;
  localparam logic [LEN_W-1:0] PILOT_HIGH_RST = 16'd27;
  localparam logic [LEN_W-1:0] SYNC_LOW_RST   = 16'd8;
  localparam logic [LEN_W-1:0] SYNC_HIGH_RST  = 16'd6;
  localparam logic [LEN_W-1:0] LONG_LOW_RST   = 16'd21;
  localparam logic [LEN_W-1:0] LONG_HIGH_RST  = 16'd21;
  localparam logic [LEN_W-1:0] SHORT_LOW_RST  = 16'd11;
  localparam logic [LEN_W-1:0] SHORT_HIGH_RST = 16'd11;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_DATA,
    JOB_END
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic              block_kind;
    logic [BYTE_W-1:0] data_byte;
    logic              checksum_ok;
  } job_t;

  typedef struct packed {
    logic [LEN_W-1:0] pilot_low;
    logic [LEN_W-1:0] pilot_high;
    logic [LEN_W-1:0] sync_lo;
    logic [LEN_W-1:0] sync_hi;
    logic [LEN_W-1:0] long_low;
    logic [LEN_W-1:0] long_high;
    logic [LEN_W-1:0] short_low;
    logic [LEN_W-1:0] short_high;
  } pulse_cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] low_len;
    logic [LEN_W-1:0] high_len;
    logic [REP_W-1:0] repeat_count;
    logic             checksum_ok;
    logic             last;
  } pulse_t;

endpackage

// File: sv/tape_block_pulse_encoder_unit.sv
// ----------------------------------------------------------------------------
// tape_block_pulse_encoder_unit
// Encodes tape block commands into run-length pulse descriptors.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          transaction moves
//   -------   ---------  -----------------  -------------------------------------
//   command   in         push_i / full_o    command, block_kind, data_byte
//   pulse     out        empty_o / pop_i    low/high len, repeat, checksum_ok, last
//   config    in         cfg_we_i           cfg_addr_i selects one of 8 lengths
//
// The back end emits one descriptor per cycle while a job is queued and the
// output does not stall: start gives pilot and sync, data one per bit, end one.
// The front takes one command per cycle while the job queue has room; the
// first descriptor of a command passes through the queue and the output register.
// A stalled output holds its descriptor; the queue keeps absorbing commands until full.
// Reset restores the register defaults and clears the XOR and byte count.
//
module tape_block_pulse_encoder_unit #(
  parameter int unsigned HeaderPilotPulses = tbpe_pkg::HEADER_PILOT_PULSES_DEF,
  parameter int unsigned DataPilotPulses   = tbpe_pkg::DATA_PILOT_PULSES_DEF,
  parameter int unsigned JobQueueDepth     = tbpe_pkg::JOB_QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [tbpe_pkg::CFG_A_W-1:0] cfg_addr_i,
  input  logic [tbpe_pkg::LEN_W-1:0]   cfg_wdata_i,
  // commands
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [tbpe_pkg::CMD_W-1:0]   command_i,
  input  logic                         block_kind_i,
  input  logic [tbpe_pkg::BYTE_W-1:0]  data_byte_i,
  // pulse descriptors
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [tbpe_pkg::LEN_W-1:0]   low_len_o,
  output logic [tbpe_pkg::LEN_W-1:0]   high_len_o,
  output logic [tbpe_pkg::REP_W-1:0]   repeat_count_o,
  output logic                         checksum_ok_o,
  output logic                         last_o
);
  import tbpe_pkg::*;

  pulse_cfg_t cfg_q;
  logic       q_push, q_full, q_pop, q_empty;
  job_t       push_job, head_job;
  logic       out_valid;
  pulse_t     out_pulse;

  // Length registers; software writes them only while the unit is idle (the block does not enforce it).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pilot_low  <= PILOT_LOW_RST;
      cfg_q.pilot_high <= PILOT_HIGH_RST;
      cfg_q.sync_lo    <= SYNC_LOW_RST;
      cfg_q.sync_hi    <= SYNC_HIGH_RST;
      cfg_q.long_low   <= LONG_LOW_RST;
      cfg_q.long_high  <= LONG_HIGH_RST;
      cfg_q.short_low  <= SHORT_LOW_RST;
      cfg_q.short_high <= SHORT_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PILOT_LOW:  cfg_q.pilot_low  <= cfg_wdata_i;
        REG_PILOT_HIGH: cfg_q.pilot_high <= cfg_wdata_i;
        REG_SYNC_LOW:   cfg_q.sync_lo    <= cfg_wdata_i;
        REG_SYNC_HIGH:  cfg_q.sync_hi    <= cfg_wdata_i;
        REG_LONG_LOW:   cfg_q.long_low   <= cfg_wdata_i;
        REG_LONG_HIGH:  cfg_q.long_high  <= cfg_wdata_i;
        REG_SHORT_LOW:  cfg_q.short_low  <= cfg_wdata_i;
        REG_SHORT_HIGH: cfg_q.short_high <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: classify the command, update block checksum state.
  tbpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .command_i   (command_i),
    .block_kind_i(block_kind_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  // Decouple command intake from descriptor expansion.
  tbpe_job_queue #(
    .Depth(JobQueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .job_o  (head_job)
  );

  // Back: one descriptor per cycle into the output register while a job is queued and the output is not stalled.
  tbpe_back #(
    .HeaderPilotPulses(HeaderPilotPulses),
    .DataPilotPulses  (DataPilotPulses)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid),
    .out_o      (out_pulse),
    .pop_i      (pop_i)
  );

  assign full_o         = q_full;
  assign empty_o        = !out_valid;
  assign low_len_o      = out_pulse.low_len;
  assign high_len_o     = out_pulse.high_len;
  assign repeat_count_o = out_pulse.repeat_count;
  assign checksum_ok_o  = out_pulse.checksum_ok;
  assign last_o         = out_pulse.last;

endmodule

// File: sv/tbpe_front.sv
// ----------------------------------------------------------------------------
// tbpe_front
// Accepts commands, tracks block XOR and length, and queues one job per valid command.
// ----------------------------------------------------------------------------
module tbpe_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [tbpe_pkg::CMD_W-1:0] command_i,
  input  logic                       block_kind_i,
  input  logic [tbpe_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output tbpe_pkg::job_t             q_job_o
);
  import tbpe_pkg::*;

  logic              accept;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [1:0]        cnt_q, cnt_d;
  job_kind_e         kind;
  logic              valid_cmd;

  assign accept = push_i && !q_full_i;

  always_comb begin
    kind      = JOB_END;
    valid_cmd = 1'b1;
    xor_d     = xor_q;
    cnt_d     = cnt_q;
    unique case (command_i)
      CMD_START: begin
        kind  = JOB_START;
        xor_d = '0;
        cnt_d = '0;
      end
      CMD_DATA: begin
        kind  = JOB_DATA;
        xor_d = xor_q ^ data_byte_i;
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      CMD_END: begin
        kind = JOB_END;
      end
      default: begin
        // reserved code: drop silently
        valid_cmd = 1'b0;
      end
    endcase
  end

  assign q_push_o              = accept && valid_cmd;
  assign q_job_o.kind          = kind;
  assign q_job_o.block_kind    = block_kind_i;
  assign q_job_o.data_byte     = data_byte_i;
  assign q_job_o.checksum_ok   = (cnt_q >= 2'd2) && (xor_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      xor_q <= xor_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/tbpe_job_queue.sv
// ----------------------------------------------------------------------------
// tbpe_job_queue
// Small FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module tbpe_job_queue #(
  parameter int unsigned Depth = tbpe_pkg::JOB_QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbpe_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tbpe_pkg::job_t job_o
);
  import tbpe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("job queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("front pushed into a full job queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("back popped an empty job queue");

endmodule

// File: sv/tbpe_back.sv
// ----------------------------------------------------------------------------
// tbpe_back
// Expands each queued job into pulse descriptors, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module tbpe_back #(
  parameter int unsigned HeaderPilotPulses = tbpe_pkg::HEADER_PILOT_PULSES_DEF,
  parameter int unsigned DataPilotPulses   = tbpe_pkg::DATA_PILOT_PULSES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbpe_pkg::pulse_cfg_t cfg_i,
  input  logic                 q_empty_i,
  input  tbpe_pkg::job_t       q_job_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  output tbpe_pkg::pulse_t     out_o,
  input  logic                 pop_i
);
  import tbpe_pkg::*;

  logic [2:0] step_q, step_d;
  logic       out_valid_q;
  pulse_t     res_d, res_q;
  logic       advance;
  logic       bit_one;

  assign advance = !q_empty_i && (!out_valid_q || pop_i);
  assign bit_one = q_job_i.data_byte[3'd7 - step_q];

  always_comb begin
    res_d.low_len      = cfg_i.pilot_low;
    res_d.high_len     = cfg_i.pilot_high;
    res_d.repeat_count = REP_W'(1);
    res_d.checksum_ok  = 1'b0;
    res_d.last         = 1'b0;
    unique case (q_job_i.kind)
      JOB_START: begin
        if (step_q == 3'd0) begin
          res_d.repeat_count = q_job_i.block_kind ? REP_W'(DataPilotPulses)
                                                  : REP_W'(HeaderPilotPulses);
        end else begin
          res_d.low_len  = cfg_i.sync_lo;
          res_d.high_len = cfg_i.sync_hi;
          res_d.last     = 1'b1;
        end
      end
      JOB_DATA: begin
        res_d.low_len  = bit_one ? cfg_i.long_low  : cfg_i.short_low;
        res_d.high_len = bit_one ? cfg_i.long_high : cfg_i.short_high;
        res_d.last     = (step_q == 3'd7);
      end
      JOB_END: begin
        res_d.high_len    = '0;
        res_d.checksum_ok = q_job_i.checksum_ok;
        res_d.last        = 1'b1;
      end
      default: begin
        res_d.last = 1'b1;
      end
    endcase
  end

  // retire the job with its final descriptor
  assign q_pop_o = advance && res_d.last;

  always_comb begin
    step_d = step_q;
    if (advance) begin
      step_d = res_d.last ? 3'd0 : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

  a_mid_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 3'd0 |-> !q_empty_i &&
      (q_job_i.kind == JOB_DATA || (q_job_i.kind == JOB_START && step_q == 3'd1)))
    else $error("step counter inside a job that is no longer queued");

  a_ok_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.checksum_ok |-> res_q.last && res_q.high_len == '0)
    else $error("checksum flag on a descriptor that is not an end pause");

  a_step_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> step_q == 3'd0)
    else $error("step counter not rewound after job retire");

endmodule
